[design/tpi_pkg.sv]
package tpi_pkg;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } plane_t;

  typedef struct packed {
    logic signed [31:0] meet_x;
    logic signed [31:0] meet_y;
    logic signed [31:0] meet_z;
    logic               degenerate;
    logic               clipped;
  } meet_t;

  localparam int unsigned QuotBits = 32;

endpackage

[design/three_plane_intersection.sv]
// Three-plane intersection by Cramer's rule, Q16.16 fixed point.
// Request channel "plane": one plane per request (integer normal, Q16.16
// point), valid/stall handshake. Result channel "meet": one result for every
// third plane, carrying the common point, a degenerate flag (zero
// determinant, coordinates zero) and a clipped flag (a coordinate saturated).
// The first two planes of a triple are only stored.
// The third plane starts the solve on one shared 34x34 multiply-accumulate
// unit and a one-bit-per-cycle restoring divider:
//   the MAC forms the offsets, the cross products, the determinant and the
//   numerators, then per coordinate come a rounding setup step, the divide
//   and a step that saturates and stores the quotient, then the publish step.
// A degenerate triple skips the divider steps, and no new plane is taken
// until the result is published. plane_stall is high while the solve runs.
// The result sits in an output register; the next triple's first planes are
// taken while it waits. If the receiver stalls, the finished solve holds in
// its last state until the output register frees up.
// Reset (synchronous, active high) empties the output register and starts a
// new triple; stored planes keep no reset value.
module three_plane_intersection (
  input  logic            clk,
  input  logic            rst,
  input  logic            plane_valid,
  output logic            plane_stall,
  input  tpi_pkg::plane_t plane,
  output logic            meet_valid,
  input  logic            meet_stall,
  output tpi_pkg::meet_t  meet
);

  typedef enum logic [3:0] {
    IDLE, DOT, CROSS, DET, NUM, DIVSET, DIVRUN, DIVEND, FIN
  } state_t;

  state_t state;
  logic [1:0] planes_held;
  logic [1:0] i, k, crd;
  logic       j;
  logic [4:0] bitc;

  // plane storage: each plane lands in slot planes_held, the third in slot two
  logic signed [15:0] nrm [3][3];
  logic signed [31:0] pnt [3][3];
  logic signed [50:0] dv  [3];
  logic signed [32:0] cr  [3][3];
  logic signed [87:0] num [3];
  logic signed [51:0] det;
  logic signed [31:0] res [3];
  logic               degen, clip_all, ovf;

  logic signed [87:0] acc, acc_next, term, ext;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic               msub, msh, mfirst;

  // divider
  logic [89:0] nq, nq_init;
  logic [87:0] mag;
  logic [50:0] ad;
  logic [51:0] dd;
  logic [51:0] rem;
  logic [52:0] rem2;
  logic        ge, neg;
  logic [31:0] q, limit, mq;

  function automatic logic [1:0] nx(input logic [1:0] v);
    nx = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  assign plane_stall = (state != IDLE);

  // operand selection for the shared MAC
  always_comb begin
    ma = '0;
    mb = '0;
    msub = 1'b0;
    msh = 1'b0;
    mfirst = 1'b0;
    unique case (state)
      DOT: begin
        ma = 34'(nrm[i][k]);
        mb = 34'(pnt[i][k]);
        mfirst = (k == 2'd0);
      end
      CROSS: begin
        ma = j ? 34'(nrm[nx(i)][nx(nx(k))]) : 34'(nrm[nx(i)][nx(k)]);
        mb = j ? 34'(nrm[nx(nx(i))][nx(k)]) : 34'(nrm[nx(nx(i))][nx(nx(k))]);
        msub = j;
        mfirst = !j;
      end
      DET: begin
        ma = 34'(nrm[2'd0][k]);
        mb = 34'(cr[2'd0][k]);
        mfirst = (k == 2'd0);
      end
      NUM: begin
        // low 25 bits of the offset unsigned, upper part signed and shifted
        ma = j ? 34'($signed(dv[i][50:25])) : $signed({9'd0, dv[i][24:0]});
        mb = 34'(cr[i][k]);
        msh = j;
        mfirst = (i == 2'd0) && !j;
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign ext = 88'(prod);
  assign term = msh ? (ext <<< 25) : ext;
  assign acc_next = (mfirst ? 88'sd0 : acc) + (msub ? -term : term);

  // divider datapath
  assign neg = num[crd][87] ^ det[51];
  assign mag = num[crd][87] ? 88'(-num[crd]) : 88'(num[crd]);
  assign ad = det[51] ? 51'(-det) : 51'(det);
  assign dd = {ad, 1'b0};
  assign nq_init = {1'b0, mag, 1'b0} + {39'd0, ad};
  assign rem2 = {rem, nq[31]};
  assign ge = (rem2 >= {1'b0, dd});
  assign limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign mq = (ovf || q > limit) ? limit : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      planes_held <= '0;
      meet_valid <= 1'b0;
      i <= '0;
      k <= '0;
      j <= 1'b0;
      crd <= '0;
      bitc <= '0;
    end else begin
      // drop a taken result unless a new one replaces it this cycle
      if (meet_valid && !meet_stall && state != FIN) meet_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (plane_valid) begin
            nrm[planes_held][0] <= plane.normal_x;
            nrm[planes_held][1] <= plane.normal_y;
            nrm[planes_held][2] <= plane.normal_z;
            pnt[planes_held][0] <= plane.point_x;
            pnt[planes_held][1] <= plane.point_y;
            pnt[planes_held][2] <= plane.point_z;
            if (planes_held == 2'd2) begin
              planes_held <= '0;
              state <= DOT;
              i <= '0;
              k <= '0;
              j <= 1'b0;
            end else begin
              planes_held <= planes_held + 2'd1;
            end
          end
        end
        DOT: begin
          acc <= acc_next;
          if (k == 2'd2) begin
            dv[i] <= acc_next[50:0];
            k <= '0;
            i <= nx(i);
            if (i == 2'd2) state <= CROSS;
          end else begin
            k <= k + 2'd1;
          end
        end
        CROSS: begin
          acc <= acc_next;
          j <= !j;
          if (j) begin
            cr[i][k] <= acc_next[32:0];
            k <= nx(k);
            if (k == 2'd2) begin
              i <= nx(i);
              if (i == 2'd2) state <= DET;
            end
          end
        end
        DET: begin
          acc <= acc_next;
          k <= nx(k);
          if (k == 2'd2) begin
            det <= acc_next[51:0];
            state <= NUM;
          end
        end
        NUM: begin
          acc <= acc_next;
          j <= !j;
          if (j) begin
            i <= nx(i);
            if (i == 2'd2) begin
              num[k] <= acc_next;
              k <= nx(k);
              if (k == 2'd2) begin
                crd <= '0;
                clip_all <= 1'b0;
                degen <= (det == 52'sd0);
                state <= (det == 52'sd0) ? FIN : DIVSET;
              end
            end
          end
        end
        DIVSET: begin
          // quotient of (2|num| + |det|) / 2|det| must fit 32 bits
          nq <= nq_init;
          ovf <= (nq_init >= {6'd0, dd, 32'd0});
          rem <= nq_init[83:32];
          bitc <= '0;
          state <= (nq_init >= {6'd0, dd, 32'd0}) ? DIVEND : DIVRUN;
        end
        DIVRUN: begin
          rem <= ge ? 52'(rem2 - {1'b0, dd}) : rem2[51:0];
          q <= {q[30:0], ge};
          nq <= {nq[88:0], 1'b0};
          bitc <= bitc + 5'd1;
          if (bitc == 5'(tpi_pkg::QuotBits - 1)) state <= DIVEND;
        end
        DIVEND: begin
          res[crd] <= neg ? -$signed(mq) : $signed(mq);
          if (ovf || q > limit) clip_all <= 1'b1;
          crd <= crd + 2'd1;
          state <= (crd == 2'd2) ? FIN : DIVSET;
        end
        FIN: begin
          if (!meet_valid || !meet_stall) begin
            meet_valid <= 1'b1;
            meet.meet_x <= degen ? 32'sd0 : res[0];
            meet.meet_y <= degen ? 32'sd0 : res[1];
            meet.meet_z <= degen ? 32'sd0 : res[2];
            meet.degenerate <= degen;
            meet.clipped <= degen ? 1'b0 : clip_all;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    planes_held != 2'd3) else $error("plane count out of range");

  a_third_starts: assert property (@(posedge clk) disable iff (rst)
    (plane_valid && !plane_stall && planes_held == 2'd2) |=> state == DOT)
    else $error("third plane did not start the solve");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (meet_valid && meet.degenerate) |->
      (meet.meet_x == 32'sd0 && meet.meet_y == 32'sd0 && meet.meet_z == 32'sd0
       && !meet.clipped)) else $error("degenerate result not zero");

endmodule
